@@ design/fcba_pkg.sv @@
// Shared types, codes and constants of the FAT chain block allocator.
`timescale 1ns / 1ps

package fcba_pkg;

    localparam int DISK_MAX_DEF   = 64;
    localparam int NAME_COUNT_DEF = 26;
    localparam int CHUNK_BITS     = 8;

    localparam logic [7:0] LINK_END     = 8'hFF;
    localparam logic [7:0] START_EMPTY  = 8'hFF;
    localparam logic [7:0] START_ABSENT = 8'hFE;

    typedef enum logic [1:0] {
        CMD_FORMAT = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNFORMATTED = 3'd1,
        ST_NOSPACE     = 3'd2,
        ST_NOTFOUND    = 3'd3,
        ST_INUSE       = 3'd4,
        ST_EMPTY       = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,
        S_ALLOC,
        S_ALLOC_END,
        S_RD_ADDR,
        S_RD_EMIT,
        S_DL_ADDR,
        S_DL_STEP,
        S_REPLY
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  block_index;
        logic        block_valid;
        logic        last;
    } res_t;

endpackage

@@ design/fcba_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/fat_chain_block_allocator.sv @@
// Top level of the FAT chain block allocator: command sequencer, tables and result register.
`timescale 1ns / 1ps

// The block accepts one command at a time and drops s_ready until the last result of that
// command is loaded into the output register. Create sums the free count eight blocks per
// cycle, then one scan pass visits the blocks below the disk size in order until the request
// is met. Read passes through S_RD_ADDR for the registered read of the link memory, then
// gives one block per cycle as long as m_ready stays high. Delete likewise passes through
// S_DL_ADDR, then walks the chain in S_DL_STEP and frees each block.
module fat_chain_block_allocator
    import fcba_pkg::*;
#(
    parameter int DISK_MAX   = DISK_MAX_DEF,
    parameter int NAME_COUNT = NAME_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [4:0] s_file_name,
    input  logic [6:0] s_block_count,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [5:0] m_block_index,
    output logic       m_block_valid,
    output logic       m_last
);

    localparam int AW     = $clog2(DISK_MAX);
    localparam int SW     = $clog2(DISK_MAX + 1);
    localparam int NIW    = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
    localparam int NCHUNK = (DISK_MAX + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PW     = $clog2(NCHUNK * CHUNK_BITS);
    localparam logic [6:0] DISK_MAX_W = 7'(DISK_MAX);
    localparam logic [7:0] DISK_MAX_B = 8'(DISK_MAX);

    state_t           state_reg, state_next;
    logic [6:0]       disk_blocks_reg;
    logic [DISK_MAX-1:0] used_reg, used_next;
    logic [7:0]       file_start_reg [NAME_COUNT];
    logic [NIW-1:0]   name_reg, name_next;
    logic [6:0]       count_reg, count_next;
    logic [6:0]       free_reg, free_next;
    logic [CW-1:0]    chunk_reg, chunk_next;
    logic [SW-1:0]    scan_reg, scan_next;
    logic [SW-1:0]    steps_reg, steps_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    prev_reg, prev_next;
    logic             have_prev_reg, have_prev_next;
    logic [AW-1:0]    start_reg, start_next;
    status_t          rep_status_reg, rep_status_next;
    logic [5:0]       rep_block_reg, rep_block_next;
    logic             rep_valid_reg, rep_valid_next;

    logic             m_valid_reg;
    res_t             m_data_reg;
    logic             out_free;
    logic             out_load;
    res_t             out_data;

    logic             fs_clear;
    logic             fs_we;
    logic [NIW-1:0]   fs_idx;
    logic [7:0]       fs_wdata;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    logic [6:0]       sz;
    logic [NIW-1:0]   name_idx;
    logic             name_ok;
    logic [7:0]       start_val;
    logic [NCHUNK*CHUNK_BITS-1:0] used_pad;
    logic [PW-1:0]    chunk_base;
    logic [CHUNK_BITS-1:0] chunk_used;
    logic [3:0]       chunk_cnt;
    logic             walk_end;

    assign sz        = (disk_blocks_reg > DISK_MAX_W) ? DISK_MAX_W : disk_blocks_reg;
    assign name_idx  = s_file_name[NIW-1:0];
    assign name_ok   = (s_file_name < 5'(NAME_COUNT));
    assign start_val = file_start_reg[name_idx];
    assign out_free  = !m_valid_reg || m_ready;
    assign walk_end  = (ram_rdata >= DISK_MAX_B) || ((steps_reg + 1'b1) >= SW'(DISK_MAX));
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        used_pad = '1;
        used_pad[DISK_MAX-1:0] = used_reg;
        chunk_base = PW'({chunk_reg, 3'b000});
        chunk_used = used_pad[chunk_base +: CHUNK_BITS];
        chunk_cnt = '0;
        for (int b = 0; b < CHUNK_BITS; b++) begin
            if (!chunk_used[b] && ((7'(chunk_base) + 7'(b)) < sz)) begin
                chunk_cnt = chunk_cnt + 4'd1;
            end
        end
    end

    fcba_ram #(
        .WIDTH(8),
        .DEPTH(DISK_MAX)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        name_next       = name_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        chunk_next      = chunk_reg;
        scan_next       = scan_reg;
        steps_next      = steps_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        start_next      = start_reg;
        rep_status_next = rep_status_reg;
        rep_block_next  = rep_block_reg;
        rep_valid_next  = rep_valid_reg;
        fs_clear        = 1'b0;
        fs_we           = 1'b0;
        fs_idx          = name_reg;
        fs_wdata        = START_ABSENT;
        ram_we          = 1'b0;
        ram_waddr       = prev_reg;
        ram_wdata       = LINK_END;
        ram_raddr       = pos_reg;
        out_load        = 1'b0;
        out_data        = '{status: ST_OK, block_index: 6'd0, block_valid: 1'b0, last: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    name_next       = name_idx;
                    count_next      = s_block_count;
                    free_next       = '0;
                    chunk_next      = '0;
                    steps_next      = '0;
                    pos_next        = start_val[AW-1:0];
                    rep_status_next = ST_OK;
                    rep_block_next  = '0;
                    rep_valid_next  = 1'b0;
                    state_next      = S_REPLY;
                    if (cmd_t'(s_cmd) == CMD_FORMAT) begin
                        used_next = '0;
                        fs_clear  = 1'b1;
                        rep_status_next = (sz == 7'd0) ? ST_UNFORMATTED : ST_OK;
                    end else if (sz == 7'd0) begin
                        rep_status_next = ST_UNFORMATTED;
                    end else if (cmd_t'(s_cmd) == CMD_CREATE) begin
                        if (!name_ok || start_val != START_ABSENT) begin
                            rep_status_next = ST_INUSE;
                        end else begin
                            state_next = S_COUNT;
                        end
                    end else if (!name_ok || start_val == START_ABSENT) begin
                        rep_status_next = ST_NOTFOUND;
                    end else if (start_val >= DISK_MAX_B) begin
                        if (cmd_t'(s_cmd) == CMD_READ) begin
                            rep_status_next = ST_EMPTY;
                        end else begin
                            fs_we  = 1'b1;
                            fs_idx = name_idx;
                        end
                    end else if (cmd_t'(s_cmd) == CMD_READ) begin
                        state_next = S_RD_ADDR;
                    end else begin
                        state_next = S_DL_ADDR;
                    end
                end
            end
            S_COUNT: begin
                free_next  = free_reg + 7'(chunk_cnt);
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CW'(NCHUNK - 1)) begin
                    if (count_reg > free_next) begin
                        rep_status_next = ST_NOSPACE;
                        state_next      = S_REPLY;
                    end else begin
                        scan_next      = '0;
                        have_prev_next = 1'b0;
                        state_next     = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (count_reg == 7'd0 || 7'(scan_reg) == sz) begin
                    state_next = S_ALLOC_END;
                end else begin
                    scan_next = scan_reg + 1'b1;
                    if (!used_reg[scan_reg[AW-1:0]]) begin
                        used_next[scan_reg[AW-1:0]] = 1'b1;
                        if (have_prev_reg) begin
                            ram_we    = 1'b1;
                            ram_wdata = 8'(scan_reg);
                        end else begin
                            start_next = scan_reg[AW-1:0];
                        end
                        prev_next      = scan_reg[AW-1:0];
                        have_prev_next = 1'b1;
                        count_next     = count_reg - 7'd1;
                    end
                end
            end
            S_ALLOC_END: begin
                fs_we      = 1'b1;
                state_next = S_REPLY;
                if (have_prev_reg) begin
                    ram_we         = 1'b1;
                    fs_wdata       = 8'(start_reg);
                    rep_block_next = 6'(start_reg);
                    rep_valid_next = 1'b1;
                end else begin
                    fs_wdata = START_EMPTY;
                end
            end
            S_RD_ADDR: begin
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{status: ST_OK, block_index: 6'(pos_reg),
                                 block_valid: 1'b1, last: walk_end};
                    if (walk_end) begin
                        state_next = S_IDLE;
                    end else begin
                        pos_next   = ram_rdata[AW-1:0];
                        ram_raddr  = ram_rdata[AW-1:0];
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            S_DL_ADDR: begin
                state_next = S_DL_STEP;
            end
            S_DL_STEP: begin
                used_next[pos_reg] = 1'b0;
                if (walk_end) begin
                    fs_we      = 1'b1;
                    state_next = S_REPLY;
                end else begin
                    pos_next   = ram_rdata[AW-1:0];
                    ram_raddr  = ram_rdata[AW-1:0];
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_data   = '{status: rep_status_reg, block_index: rep_block_reg,
                                   block_valid: rep_valid_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            disk_blocks_reg <= '0;
            used_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_wr_en) begin
                disk_blocks_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NAME_COUNT; n++) begin
                file_start_reg[n] <= START_ABSENT;
            end
        end else if (fs_clear) begin
            for (int n = 0; n < NAME_COUNT; n++) begin
                file_start_reg[n] <= START_ABSENT;
            end
        end else if (fs_we) begin
            file_start_reg[fs_idx] <= fs_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        name_reg       <= name_next;
        count_reg      <= count_next;
        free_reg       <= free_next;
        chunk_reg      <= chunk_next;
        scan_reg       <= scan_next;
        steps_reg      <= steps_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        have_prev_reg  <= have_prev_next;
        start_reg      <= start_next;
        rep_status_reg <= rep_status_next;
        rep_block_reg  <= rep_block_next;
        rep_valid_reg  <= rep_valid_next;
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_data_reg.status;
    assign m_block_index = m_data_reg.block_index;
    assign m_block_valid = m_data_reg.block_valid;
    assign m_last        = m_data_reg.last;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Block stayed ready after taking a command.");

    a_ram_write_in_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_ALLOC || state_reg == S_ALLOC_END))
        else $error("Link memory written outside allocation.");

    a_alloc_stops_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ALLOC && count_reg == 7'd0 |=> state_reg == S_ALLOC_END)
        else $error("Allocation continued after the request was met.");

    a_partial_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !out_data.last |-> state_reg == S_RD_EMIT)
        else $error("Non-final result produced outside a chain read.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("Result register loaded while holding an untaken transfer.");

endmodule
